>>> rtl/lwms_pkg.sv
`default_nettype none

package lwms_pkg;

  // Frame and window limits.
  localparam int MaxWidth   = 256;
  localparam int MaxHeight  = 256;
  localparam int MaxWindow  = 15;
  localparam int MinWindow  = 3;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int RowW       = $clog2(MaxHeight);
  localparam int FrameAw    = RowW + ColW;
  localparam int FrameDepth = MaxWidth * MaxHeight;
  localparam int PixelW     = 8;

  // Shared divide / square-root unit.
  localparam int ArithW = 48;
  localparam int DenW   = 16;
  localparam int RootW  = 16;
  localparam int RemW   = 19;
  localparam int StepW  = 6;

  localparam logic [StepW-1:0] StepsMean = 6'd24;
  localparam logic [StepW-1:0] StepsVar  = 6'd48;
  localparam logic [StepW-1:0] StepsSqrt = 6'd16;

  // Item operation codes.
  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  // Result status codes.
  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatOutside  = 2'd1;
  localparam logic [1:0] StatTooLarge = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [1:0] RegWindowSize  = 2'd0;
  localparam logic [1:0] RegImageWidth  = 2'd1;
  localparam logic [1:0] RegImageHeight = 2'd2;

  typedef struct packed {
    logic              start;
    logic              is_sqrt;
    logic [StepW-1:0]  steps;
    logic [ArithW-1:0] num;
    logic [DenW-1:0]   den;
  } arith_cmd_t;

  typedef struct packed {
    logic              done;
    logic [ArithW-1:0] quotient;
    logic [RootW-1:0]  root;
  } arith_rsp_t;

endpackage

`default_nettype wire

>>> rtl/lwms_if.sv
`default_nettype none

interface lwms_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] row;
  logic [7:0] col;
  logic [7:0] pixel;

  modport source (output valid, output operation, output row, output col, output pixel,
                  input ready);
  modport sink (input valid, input operation, input row, input col, input pixel,
                output ready);
endinterface

interface lwms_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] mean_q8;
  logic [14:0] stdev_q8;
  logic [1:0]  status;

  modport source (output valid, output mean_q8, output stdev_q8, output status,
                  input ready);
  modport sink (input valid, input mean_q8, input stdev_q8, input status,
                output ready);
endinterface

`default_nettype wire

>>> rtl/lwms_ram.sv
`default_nettype none

module lwms_ram #(
  parameter int Width = 8,
  parameter int Depth = 256,
  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/lwms_arith.sv
`default_nettype none

module lwms_arith (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lwms_pkg::arith_cmd_t cmd_i,
  output lwms_pkg::arith_rsp_t rsp_o
);
  import lwms_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [StepW-1:0]  cnt_q, cnt_d;
  logic              sqrt_q;
  logic [ArithW-1:0] acc_q;
  logic [RemW-1:0]   rem_q;
  logic [RootW-1:0]  root_q;
  logic [DenW-1:0]   den_q;

  logic [RemW-1:0]   shifted;
  logic [RemW-1:0]   trial;
  logic [RemW:0]     diff;
  logic              ge;

  // One restoring step: long division brings down one bit, the square root two.
  always_comb begin
    if (sqrt_q) begin
      shifted = {rem_q[RemW-3:0], acc_q[ArithW-1 -: 2]};
      trial   = RemW'({root_q, 2'b01});
    end else begin
      shifted = {rem_q[RemW-2:0], acc_q[ArithW-1]};
      trial   = RemW'(den_q);
    end
    diff = {1'b0, shifted} - {1'b0, trial};
    ge   = ~diff[RemW];
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (cmd_i.start) begin
      busy_d = 1'b1;
      cnt_d  = cmd_i.steps;
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      sqrt_q <= cmd_i.is_sqrt;
      acc_q  <= cmd_i.num;
      den_q  <= cmd_i.den;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[RemW-1:0] : shifted;
      if (sqrt_q) begin
        acc_q  <= {acc_q[ArithW-3:0], 2'b00};
        root_q <= {root_q[RootW-2:0], ge};
      end else begin
        acc_q <= {acc_q[ArithW-2:0], ge};
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = acc_q;
  assign rsp_o.root     = root_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_i.start |-> !busy_q)
    else $error("arith unit started while a job is still running");
`endif

endmodule

`default_nettype wire

>>> rtl/local_window_mean_stdev_unit.sv
`default_nettype none

// Local window mean and standard deviation over an 8-bit frame of up to 256 x 256
// pixels. A load item writes one pixel and gives no result; the block takes the
// next item in the following cycle. A query item reads the side x side window
// around the pixel one frame-store read per cycle (mirrored at the frame edges),
// then runs one shared shift-and-subtract unit for the mean division (24 steps), the
// variance division (48 steps) and the square root (16 steps). The query result is
// then placed in the output register; the input is not ready while a query is in
// progress. Queries outside the frame or with a window of twice a frame dimension
// or more finish with a nonzero status. Reading a pixel that was never loaded
// gives undefined statistics.
module local_window_mean_stdev_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  lwms_in_if.sink     in_i,
  lwms_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lwms_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_READ  = 8'b0000_0010,
    ST_DRAIN = 8'b0000_0100,
    ST_MUL   = 8'b0000_1000,
    ST_DIVM  = 8'b0001_0000,
    ST_DIVV  = 8'b0010_0000,
    ST_SQRT  = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_e;

  function automatic logic [7:0] mirror_coord(input logic signed [10:0] p,
                                              input logic [8:0] n);
    logic signed [10:0] m;
    logic signed [10:0] ns;
    ns = $signed({2'b00, n});
    m  = p;
    if (m < 0) m = -m;
    if (m >= ns) m = (ns <<< 1) - m - 11'sd2;
    if (m < 0) m = '0;
    if (m >= ns) m = ns - 11'sd1;
    return m[7:0];
  endfunction

  state_e state_q, state_d;

  logic [3:0] window_q;
  logic [8:0] width_q, height_q;

  logic [8:0] w_use, h_use;
  logic [3:0] cw;
  logic [2:0] half;
  logic [3:0] side;
  logic signed [3:0] pos_half, neg_half;

  logic        cfg_wr;
  logic        in_fire;
  logic        outside, too_large;

  logic [7:0]        r_q, c_q;
  logic signed [3:0] k_q, l_q;
  logic              rd_valid_q;
  logic [15:0]       s_q;
  logic [23:0]       q_q;
  logic [7:0]        n_q;
  logic [31:0]       nq_q, ss_q;
  logic [15:0]       nn_q;
  logic [31:0]       var_num;

  logic [15:0] mean_q;
  logic [14:0] stdev_q;
  logic [1:0]  status_q;

  logic        out_valid_q;
  logic [15:0] out_mean_q;
  logic [14:0] out_stdev_q;
  logic [1:0]  out_status_q;

  logic signed [10:0] py, px;
  logic [7:0]         row_rd, col_rd;
  logic               rd_en;
  logic [PixelW-1:0]  rd_data;
  logic               ram_we;
  logic [15:0]        pix_sq;

  arith_cmd_t arith_cmd;
  arith_rsp_t arith_rsp;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= 4'd3;
      width_q  <= 9'd256;
      height_q <= 9'd256;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegWindowSize:  window_q <= pwdata[3:0];
        RegImageWidth:  width_q  <= pwdata[8:0];
        RegImageHeight: height_q <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegWindowSize:  prdata = {28'd0, window_q};
      RegImageWidth:  prdata = {23'd0, width_q};
      RegImageHeight: prdata = {23'd0, height_q};
      default:        prdata = '0;
    endcase
  end

  // Clamped frame size and window geometry.
  always_comb begin
    if (width_q == 9'd0) w_use = 9'd1;
    else if (width_q > 9'(MaxWidth)) w_use = 9'(MaxWidth);
    else w_use = width_q;
    if (height_q == 9'd0) h_use = 9'd1;
    else if (height_q > 9'(MaxHeight)) h_use = 9'(MaxHeight);
    else h_use = height_q;
    if (window_q < 4'(MinWindow)) cw = 4'(MinWindow);
    else if (window_q > 4'(MaxWindow)) cw = 4'(MaxWindow);
    else cw = window_q;
    half     = cw[3:1];
    side     = {half, 1'b1};
    pos_half = $signed({1'b0, half});
    neg_half = 4'sd0 - pos_half;
  end

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid & in_i.ready;

  assign outside   = ({1'b0, in_i.row} >= h_use) || ({1'b0, in_i.col} >= w_use);
  assign too_large = ({6'd0, side} >= {h_use, 1'b0}) || ({6'd0, side} >= {w_use, 1'b0});

  // Window addressing with mirrored edges.
  assign py     = $signed({3'b000, r_q}) + $signed({{7{k_q[3]}}, k_q});
  assign px     = $signed({3'b000, c_q}) + $signed({{7{l_q[3]}}, l_q});
  assign row_rd = mirror_coord(py, h_use);
  assign col_rd = mirror_coord(px, w_use);
  assign rd_en  = (state_q == ST_READ);

  assign ram_we = in_fire && (in_i.operation == OpLoad) && !outside;

  lwms_ram #(
    .Width (PixelW),
    .Depth (FrameDepth)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i ({in_i.row[RowW-1:0], in_i.col[ColW-1:0]}),
    .wdata_i (in_i.pixel),
    .re_i    (rd_en),
    .raddr_i ({row_rd[RowW-1:0], col_rd[ColW-1:0]}),
    .rdata_o (rd_data)
  );

  assign pix_sq  = {8'd0, rd_data} * {8'd0, rd_data};
  assign var_num = nq_q - ss_q;

  // Commands to the shared divide / square-root unit.
  always_comb begin
    arith_cmd = '0;
    case (state_q)
      ST_MUL: begin
        arith_cmd.start = 1'b1;
        arith_cmd.steps = StepsMean;
        arith_cmd.num   = {s_q, 8'h00, 24'h000000};
        arith_cmd.den   = {8'h00, n_q};
      end
      ST_DIVM: begin
        arith_cmd.start = arith_rsp.done;
        arith_cmd.steps = StepsVar;
        arith_cmd.num   = {var_num, 16'h0000};
        arith_cmd.den   = nn_q;
      end
      ST_DIVV: begin
        arith_cmd.start   = arith_rsp.done;
        arith_cmd.is_sqrt = 1'b1;
        arith_cmd.steps   = StepsSqrt;
        arith_cmd.num     = {arith_rsp.quotient[31:0], 16'h0000};
      end
      default: ;
    endcase
  end

  lwms_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (arith_cmd),
    .rsp_o  (arith_rsp)
  );

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && (in_i.operation == OpQuery)) begin
          state_d = (outside || too_large) ? ST_OUT : ST_READ;
        end
      end
      ST_READ: begin
        if ((l_q == pos_half) && (k_q == pos_half)) state_d = ST_DRAIN;
      end
      ST_DRAIN: state_d = ST_MUL;
      ST_MUL:   state_d = ST_DIVM;
      ST_DIVM:  if (arith_rsp.done) state_d = ST_DIVV;
      ST_DIVV:  if (arith_rsp.done) state_d = ST_SQRT;
      ST_SQRT:  if (arith_rsp.done) state_d = ST_OUT;
      ST_OUT:   if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_valid_q <= rd_en;
      if ((state_q == ST_OUT) && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire && (in_i.operation == OpQuery)) begin
          r_q     <= in_i.row;
          c_q     <= in_i.col;
          k_q     <= neg_half;
          l_q     <= neg_half;
          s_q     <= '0;
          q_q     <= '0;
          n_q     <= {4'd0, side} * {4'd0, side};
          mean_q  <= '0;
          stdev_q <= '0;
          if (outside) status_q <= StatOutside;
          else if (too_large) status_q <= StatTooLarge;
          else status_q <= StatOk;
        end
      end
      ST_READ: begin
        if (l_q == pos_half) begin
          l_q <= neg_half;
          k_q <= k_q + 4'sd1;
        end else begin
          l_q <= l_q + 4'sd1;
        end
      end
      ST_MUL: begin
        nq_q <= {24'd0, n_q} * {8'd0, q_q};
        ss_q <= {16'd0, s_q} * {16'd0, s_q};
        nn_q <= {8'd0, n_q} * {8'd0, n_q};
      end
      ST_DIVM: if (arith_rsp.done) mean_q <= arith_rsp.quotient[15:0];
      ST_SQRT: if (arith_rsp.done) stdev_q <= arith_rsp.root[14:0];
      ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_mean_q   <= mean_q;
          out_stdev_q  <= stdev_q;
          out_status_q <= status_q;
        end
      end
      default: ;
    endcase
    // The read data arrives in the cycle after its address.
    if (rd_valid_q) begin
      s_q <= s_q + {8'd0, rd_data};
      q_q <= q_q + {8'd0, pix_sq};
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.mean_q8  = out_mean_q;
  assign out_o.stdev_q8 = out_stdev_q;
  assign out_o.status   = out_status_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    arith_rsp.done |-> (state_q == ST_DIVM || state_q == ST_DIVV || state_q == ST_SQRT))
    else $error("arith unit finished outside of a query computation");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> ({1'b0, row_rd} < h_use && {1'b0, col_rd} < w_use))
    else $error("mirrored window read left the frame");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q |-> (state_q == ST_READ || state_q == ST_DRAIN))
    else $error("frame read data arrived outside the window scan");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q != StatOk) |-> (out_mean_q == '0 && out_stdev_q == '0))
    else $error("flagged query carries nonzero statistics");
`endif

endmodule

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;
  import lwms_pkg::*;

  // Index 3 has no register behind it; writes there must be dropped.
  localparam logic [1:0] RegUnused = 2'd3;
  localparam int PatchSide  = 16;
  localparam int FullFill   = 144;
  localparam int PhaseItems = 120;
  localparam int ItemTarget = 1275;
  localparam int TailCycles = 400;

  typedef struct packed {
    logic [15:0] mean_q8;
    logic [14:0] stdev_q8;
    logic [1:0]  status;
  } stats_t;

  class window_stats_model;
    bit [7:0]   pixels [65536];
    bit         loaded [65536];
    logic [3:0] window_reg;
    logic [8:0] width_reg;
    logic [8:0] height_reg;
    stats_t     stats_due [$];
    int         errors;

    function new();
      window_reg = 4'd3;
      width_reg  = 9'd256;
      height_reg = 9'd256;
      errors     = 0;
    endfunction

    function int clamp_dim(logic [8:0] v);
      if (v == 0) return 1;
      if (v > MaxWidth) return MaxWidth;
      return int'(v);
    endfunction

    function int frame_cols();
      return clamp_dim(width_reg);
    endfunction

    function int frame_rows();
      return clamp_dim(height_reg);
    endfunction

    function int window_side();
      int cw;
      cw = int'(window_reg);
      if (cw < MinWindow) cw = MinWindow;
      if (cw > MaxWindow) cw = MaxWindow;
      return 2 * (cw / 2) + 1;
    endfunction

    // Reflect about the edge pixel without repeating it.
    function int mirror_pos(int p, int n);
      if (p < 0) p = -p;
      if (p >= n) p = 2 * n - p - 2;
      if (p < 0) p = 0;
      if (p >= n) p = n - 1;
      return p;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned probe;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > v) probe >>= 2;
      while (probe != 0) begin
        if (v >= root + probe) begin
          v    = v - (root + probe);
          root = (root >> 1) + probe;
        end else begin
          root >>= 1;
        end
        probe >>= 2;
      end
      return root;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        RegWindowSize:  window_reg = value[3:0];
        RegImageWidth:  width_reg  = value[8:0];
        RegImageHeight: height_reg = value[8:0];
        default: ;
      endcase
    endfunction

    // True when a query here reads only pixels that have been loaded.
    function bit window_ready(logic [7:0] r, logic [7:0] c);
      int w, h, half, side, k, l;
      w    = frame_cols();
      h    = frame_rows();
      side = window_side();
      half = side / 2;
      if (r >= h || c >= w) return 1;
      if (side >= 2 * h || side >= 2 * w) return 1;
      for (k = -half; k <= half; k++)
        for (l = -half; l <= half; l++)
          if (!loaded[mirror_pos(r + k, h) * MaxWidth + mirror_pos(c + l, w)]) return 0;
      return 1;
    endfunction

    function void take_item(logic op, logic [7:0] r, logic [7:0] c, logic [7:0] px);
      int w, h, half, side, k, l, y, x;
      longint unsigned n, s, q, v, spread_q16;
      stats_t e;
      w    = frame_cols();
      h    = frame_rows();
      side = window_side();
      half = side / 2;
      if (op == OpLoad) begin
        if (r < h && c < w) begin
          pixels[{r, c}] = px;
          loaded[{r, c}] = 1'b1;
        end
        return;
      end
      e = '0;
      if (r >= h || c >= w) begin
        e.status = StatOutside;
      end else if (side >= 2 * h || side >= 2 * w) begin
        e.status = StatTooLarge;
      end else begin
        s = 0;
        q = 0;
        for (k = -half; k <= half; k++) begin
          y = mirror_pos(r + k, h);
          for (l = -half; l <= half; l++) begin
            x = mirror_pos(c + l, w);
            v = 64'(pixels[y * MaxWidth + x]);
            s += v;
            q += v * v;
          end
        end
        n          = 64'(side * side);
        spread_q16 = (64'd65536 * (n * q - s * s)) / (n * n);
        e.mean_q8  = 16'((64'd256 * s) / n);
        e.stdev_q8 = 15'(int_sqrt(spread_q16));
        e.status   = StatOk;
      end
      stats_due.push_back(e);
    endfunction

    function void match_result(stats_t got);
      stats_t want;
      if (stats_due.size() == 0) begin
        $display("%0t: result with none due: mean_q8 %0d stdev_q8 %0d status %0d",
                 $time, got.mean_q8, got.stdev_q8, got.status);
        errors++;
        return;
      end
      want = stats_due.pop_front();
      if (got.mean_q8 !== want.mean_q8) begin
        $display("%0t: mean_q8 expected %0d, got %0d", $time, want.mean_q8, got.mean_q8);
        errors++;
      end
      if (got.stdev_q8 !== want.stdev_q8) begin
        $display("%0t: stdev_q8 expected %0d, got %0d", $time, want.stdev_q8, got.stdev_q8);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
        errors++;
      end
    endfunction

    function int pending();
      return stats_due.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lwms_in_if  in_if ();
  lwms_out_if out_if ();

  local_window_mean_stdev_unit u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  window_stats_model stats_model;
  int items_sent;
  bit send_calm;
  int send_left;
  bit recv_calm;
  int recv_left;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Random idle counts, with runs of back-to-back items mixed in.
  function automatic int idle_draw(inout bit calm, inout int left);
    if (left == 0) begin
      calm = ($urandom_range(0, 3) == 0);
      left = $urandom_range(10, 60);
    end
    left--;
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [31:0] pick_dim();
    int mix;
    mix = $urandom_range(0, 99);
    if (mix < 60) return $urandom_range(1, 12);
    if (mix < 80) return $urandom_range(13, 40);
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 1;
      2: return 2;
      3: return 256;
      4: return 511;
      default: return $urandom_range(41, 511);
    endcase
  endfunction

  function automatic int pick_anchor(int span);
    case ($urandom_range(0, 3))
      0: return 0;
      1: return span;
      default: return $urandom_range(0, span);
    endcase
  endfunction

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    @(posedge clk_i);
    stats_model.set_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_item(input logic op, input logic [7:0] r, input logic [7:0] c,
                           input logic [7:0] px);
    int gap;
    gap = idle_draw(send_calm, send_left);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.row       <= r;
    in_if.col       <= c;
    in_if.pixel     <= px;
    do @(negedge clk_i); while (!in_if.ready);
    @(posedge clk_i);
    stats_model.take_item(op, r, c, px);
    items_sent++;
  endtask

  // Drain all due results; loads give none, so then also wait out the extra cycles asked for.
  task automatic settle(input int extra);
    in_if.valid <= 1'b0;
    while (stats_model.pending() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic query_in_patch(input int pr, input int pc, input int ph, input int pw);
    logic [7:0] r, c;
    bit found;
    int t;
    found = 1'b0;
    for (t = 0; t < 16 && !found; t++) begin
      r     = 8'(pr + $urandom_range(0, ph - 1));
      c     = 8'(pc + $urandom_range(0, pw - 1));
      found = stats_model.window_ready(r, c);
    end
    if (found) send_item(OpQuery, r, c, 8'($urandom_range(0, 255)));
    else send_item(OpLoad, r, c, rand_pixel());
  endtask

  task automatic directed_items();
    // Reset settings: 3x3 window on the full frame, corners mirror inward.
    send_item(OpLoad, 8'd0, 8'd0, 8'd255);
    send_item(OpLoad, 8'd0, 8'd1, 8'd0);
    send_item(OpLoad, 8'd1, 8'd0, 8'd0);
    send_item(OpLoad, 8'd1, 8'd1, 8'd255);
    send_item(OpQuery, 8'd0, 8'd0, 8'd0);
    send_item(OpLoad, 8'd254, 8'd254, 8'd255);
    send_item(OpLoad, 8'd254, 8'd255, 8'd255);
    send_item(OpLoad, 8'd255, 8'd254, 8'd255);
    send_item(OpLoad, 8'd255, 8'd255, 8'd255);
    send_item(OpQuery, 8'd255, 8'd255, 8'd255);
    settle(8);
    // Window below the minimum on a 2x1 frame is still too large.
    reg_write(RegWindowSize, 32'd0);
    reg_write(RegImageWidth, 32'd2);
    reg_write(RegImageHeight, 32'd1);
    reg_write(RegUnused, 32'hFFFF_FFFF);
    send_item(OpQuery, 8'd0, 8'd0, 8'd0);
    send_item(OpQuery, 8'd1, 8'd0, 8'd0);
    send_item(OpLoad, 8'd0, 8'd2, 8'd77);
    send_item(OpLoad, 8'd1, 8'd0, 8'd9);
    settle(8);
    // Width above range and height zero are clamped.
    reg_write(RegWindowSize, 32'd15);
    reg_write(RegImageWidth, 32'd511);
    reg_write(RegImageHeight, 32'd0);
    send_item(OpQuery, 8'd0, 8'd0, 8'd0);
    send_item(OpQuery, 8'd0, 8'd255, 8'd0);
    send_item(OpQuery, 8'd1, 8'd0, 8'd0);
    settle(8);
    // Even setting gives a 5x5 window over a 3x3 frame; the ignored load above
    // must not have touched the pixel at row 1, column 0.
    reg_write(RegWindowSize, 32'd4);
    reg_write(RegImageWidth, 32'd3);
    reg_write(RegImageHeight, 32'd3);
    send_item(OpLoad, 8'd0, 8'd2, 8'd200);
    send_item(OpLoad, 8'd1, 8'd2, 8'd17);
    send_item(OpLoad, 8'd2, 8'd0, 8'd128);
    send_item(OpLoad, 8'd2, 8'd1, 8'd255);
    send_item(OpLoad, 8'd2, 8'd2, 8'd1);
    send_item(OpQuery, 8'd1, 8'd1, 8'd0);
    send_item(OpQuery, 8'd2, 8'd0, 8'd0);
    send_item(OpQuery, 8'd0, 8'd2, 8'd0);
    settle(8);
  endtask

  task automatic run_phase();
    int w, h, pr, pc, ph, pw, i, j, mix;
    logic [7:0] r, c;
    reg_write(RegWindowSize, $urandom_range(0, 15));
    reg_write(RegImageWidth, pick_dim());
    reg_write(RegImageHeight, pick_dim());
    w = stats_model.frame_cols();
    h = stats_model.frame_rows();
    // Small frames are loaded whole; large ones get one loaded patch.
    if (w * h <= FullFill) begin
      pr = 0;
      pc = 0;
      ph = h;
      pw = w;
    end else begin
      ph = (h < PatchSide) ? h : PatchSide;
      pw = (w < PatchSide) ? w : PatchSide;
      pr = pick_anchor(h - ph);
      pc = pick_anchor(w - pw);
    end
    for (i = 0; i < ph; i++)
      for (j = 0; j < pw; j++)
        send_item(OpLoad, 8'(pr + i), 8'(pc + j), rand_pixel());
    for (i = 0; i < PhaseItems; i++) begin
      mix = $urandom_range(0, 99);
      if (mix < 55) begin
        query_in_patch(pr, pc, ph, pw);
      end else if (mix < 65) begin
        r = 8'($urandom_range(0, 255));
        c = 8'($urandom_range(0, 255));
        if (stats_model.window_ready(r, c)) begin
          send_item(OpQuery, r, c, 8'($urandom_range(0, 255)));
        end else begin
          query_in_patch(pr, pc, ph, pw);
        end
      end else if (mix < 90) begin
        send_item(OpLoad, 8'(pr + $urandom_range(0, ph - 1)),
                  8'(pc + $urandom_range(0, pw - 1)), rand_pixel());
      end else begin
        send_item(OpLoad, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  rand_pixel());
      end
    end
    settle(8);
  endtask

  initial begin
    stats_model = new();
    items_sent  = 0;
    send_calm   = 1'b0;
    send_left   = 0;
    rst_ni          <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    in_if.valid     <= 1'b0;
    in_if.operation <= OpLoad;
    in_if.row       <= '0;
    in_if.col       <= '0;
    in_if.pixel     <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_items();
    while (items_sent < ItemTarget) run_phase();
    settle(TailCycles);
    if (stats_model.errors == 0) begin
      $display("local_window_mean_stdev_unit: match");
    end else begin
      $display("local_window_mean_stdev_unit: mismatch");
    end
    $finish;
  end

  // Result side: random stalls, fields sampled mid-cycle while they are stable.
  initial begin
    stats_t got;
    int gap;
    recv_calm    = 1'b0;
    recv_left    = 0;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = idle_draw(recv_calm, recv_left);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(negedge clk_i); while (out_if.valid !== 1'b1);
      got.mean_q8  = out_if.mean_q8;
      got.stdev_q8 = out_if.stdev_q8;
      got.status   = out_if.status;
      @(posedge clk_i);
      stats_model.match_result(got);
    end
  end

  initial begin
    #20000000;
    $display("local_window_mean_stdev_unit: mismatch");
    $finish;
  end

endmodule

>>> filelist.f
rtl/lwms_pkg.sv
rtl/lwms_if.sv
rtl/lwms_ram.sv
rtl/lwms_arith.sv
rtl/local_window_mean_stdev_unit.sv
bench/tb.sv
